@@ sv/cocktail_shaker_sorter_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef COCKTAIL_SHAKER_SORTER_UNIT_ASSERT_SVH
`define COCKTAIL_SHAKER_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// Shared constants and types of the cocktail shaker sorter.
// ----------------------------------------------------------------------------
package css_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FLOAD,
        S_FSTEP,
        S_FEND,
        S_BSTEP,
        S_BEND,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_FLOAD,
        DP_FSTEP,
        DP_FEND,
        DP_BSTEP,
        DP_BEND,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        logic few;     // fewer than two elements stored
        logic k_last;  // pointer at the last stored element
        logic k_zero;  // pointer at the first element
        logic moved;   // current pass has swapped a pair
    } t_dp_stat;

endpackage

@@ sv/css_ctrl.sv @@
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: loading, alternating sort passes and read-out.
// ----------------------------------------------------------------------------
module css_ctrl
    import css_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_last_of_set,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_last_of_set) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = i_stat.few ? S_OUT : S_FLOAD;
            end
            S_FLOAD: begin
                n_state = S_FSTEP;
            end
            S_FSTEP: begin
                if (i_stat.k_last) begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                n_state = i_stat.moved ? S_BSTEP : S_OUT;
            end
            S_BSTEP: begin
                if (i_stat.k_zero) begin
                    n_state = S_BEND;
                end
            end
            S_BEND: begin
                n_state = i_stat.moved ? S_FSTEP : S_OUT;
            end
            S_OUT: begin
                if (i_stat.k_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:  o_op = i_start ? DP_LOAD : DP_NOP;
            S_START: o_op = DP_START;
            S_FLOAD: o_op = DP_FLOAD;
            S_FSTEP: o_op = DP_FSTEP;
            S_FEND:  o_op = DP_FEND;
            S_BSTEP: o_op = DP_BSTEP;
            S_BEND:  o_op = DP_BEND;
            S_OUT:   o_op = DP_OUT;
            default: o_op = DP_NOP;
        endcase
    end

endmodule

@@ sv/css_dpath.sv @@
// ----------------------------------------------------------------------------
// css_dpath
// Element store, bubbling carry register, pointer and result registers.
// ----------------------------------------------------------------------------
module css_dpath
    import css_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_op                   i_op,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_result,
    output logic                     o_dropped
);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd;

    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  n_k;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ovf;
    logic              n_ovf;
    logic [DATA_W-1:0] r_carry;
    logic [DATA_W-1:0] n_carry;
    logic              r_moved;
    logic              n_moved;
    logic              r_out_pend;
    logic              n_out_pend;
    logic              r_out_last;
    logic              n_out_last;
    logic              r_out_drop;
    logic              n_out_drop;

    logic              w_we;
    logic [IDX_W-1:0]  w_wa;
    logic [DATA_W-1:0] w_wd;
    logic [IDX_W-1:0]  w_ra;

    logic [IDX_W-1:0]  w_nm1;
    logic [IDX_W-1:0]  w_nm2;
    logic              w_k_last;
    logic              w_gt_fwd;
    logic              w_gt_bwd;
    logic              w_full;

    assign w_nm1    = IDX_W'(r_count - CNT_W'(1));
    assign w_nm2    = IDX_W'(r_count - CNT_W'(2));
    assign w_k_last = (r_k == w_nm1);
    assign w_gt_fwd = $signed(r_carry) > $signed(r_rd);
    assign w_gt_bwd = $signed(r_rd) > $signed(r_carry);
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    assign o_stat.few    = (r_count < CNT_W'(2));
    assign o_stat.k_last = w_k_last;
    assign o_stat.k_zero = (r_k == '0);
    assign o_stat.moved  = r_moved;

    always_comb begin
        n_k        = r_k;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_carry    = r_carry;
        n_moved    = r_moved;
        n_out_pend = 1'b0;
        n_out_last = r_out_last;
        n_out_drop = r_out_drop;
        w_we       = 1'b0;
        w_wa       = r_k;
        w_wd       = r_carry;
        w_ra       = r_k;
        case (i_op)
            DP_LOAD: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    w_we    = 1'b1;
                    w_wa    = r_count[IDX_W-1:0];
                    w_wd    = i_value;
                    n_count = r_count + CNT_W'(1);
                end
            end
            DP_START: begin
                w_ra = '0;
                n_k  = '0;
            end
            DP_FLOAD: begin
                n_carry = r_rd;
                w_ra    = IDX_W'(1);
                n_k     = IDX_W'(1);
                n_moved = 1'b0;
            end
            DP_FSTEP: begin
                // carry bubbles up while larger; drop the smaller one behind it
                w_we = 1'b1;
                w_wa = r_k - IDX_W'(1);
                w_ra = r_k + IDX_W'(1);
                n_k  = r_k + IDX_W'(1);
                if (w_gt_fwd) begin
                    w_wd    = r_rd;
                    n_moved = 1'b1;
                end else begin
                    n_carry = r_rd;
                end
            end
            DP_FEND: begin
                w_we    = 1'b1;
                w_wa    = w_nm1;
                w_ra    = w_nm2;
                n_k     = r_moved ? w_nm2 : '0;
                n_moved = 1'b0;
            end
            DP_BSTEP: begin
                // carry sinks while smaller
                w_we = 1'b1;
                w_wa = r_k + IDX_W'(1);
                w_ra = r_k - IDX_W'(1);
                n_k  = r_k - IDX_W'(1);
                if (w_gt_bwd) begin
                    w_wd    = r_rd;
                    n_moved = 1'b1;
                end else begin
                    n_carry = r_rd;
                end
            end
            DP_BEND: begin
                w_we    = 1'b1;
                w_wa    = '0;
                w_ra    = IDX_W'(1);
                n_k     = r_moved ? IDX_W'(1) : '0;
                n_moved = 1'b0;
            end
            DP_OUT: begin
                w_ra       = r_k;
                n_k        = r_k + IDX_W'(1);
                n_out_pend = 1'b1;
                n_out_last = w_k_last;
                n_out_drop = r_ovf;
                if (w_k_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_moved    <= 1'b0;
            r_out_pend <= 1'b0;
            r_k        <= '0;
        end else begin
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_moved    <= n_moved;
            r_out_pend <= n_out_pend;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry    <= n_carry;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    assign o_strobe       = r_out_pend;
    assign o_sorted_value = $signed(r_rd);
    assign o_last_result  = r_out_last;
    assign o_dropped      = r_out_drop;

endmodule

@@ sv/cocktail_shaker_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_unit
// Collects a set of signed values and returns it sorted ascending.
// ----------------------------------------------------------------------------
// Input: drive i_value and i_last_of_set with start high; the beat is taken
// at an edge where busy is low. Up to CAPACITY values are kept per set; any
// further value is discarded and o_dropped is set on every result of that set.
// One beat is loaded per cycle while busy is low. After the beat flagged
// i_last_of_set busy rises and the set of n elements is sorted in the element
// store by alternating forward and backward passes, ending after the first
// pass without a swap (at most about n passes).
// The single-port-read store, one element a cycle, sets the pass length.
// Read-out: n results on consecutive cycles, each marked by o_strobe for one
// cycle, the final one with o_last_result; the first strobe follows the end
// of the last pass, or the start step alone for a single element.
// busy falls with the final strobe.
// The receiver cannot stall: results must be taken as they appear.
// Reset (synchronous, active low) empties the set and aborts any sort.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_unit
    import css_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last_of_set,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_result,
    output logic                     o_dropped
);

    t_dp_op   w_op;
    t_dp_stat w_stat;

    css_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_last_of_set (i_last_of_set),
        .i_stat        (w_stat),
        .o_op          (w_op),
        .o_busy        (busy)
    );

    css_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_value        (i_value),
        .o_stat         (w_stat),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_dropped      (o_dropped)
    );

endmodule

@@ sv/css_checker.sv @@
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks on the sorter's result stream and on the start of a sort.
// ----------------------------------------------------------------------------
`include "cocktail_shaker_sorter_unit_assert.svh"

module css_checker
    import css_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_of_set,
    input logic o_strobe,
    input logic o_last_result,
    input logic o_dropped
);

    `CSS_ASSERT_NXT(a_burst_contiguous, i_clk, i_rst_n,
        o_strobe && !o_last_result, o_strobe, "result burst broken")
    `CSS_ASSERT_NXT(a_burst_ends, i_clk, i_rst_n,
        o_strobe && o_last_result, !o_strobe, "beat after final result")
    `CSS_ASSERT_IMP(a_busy_in_burst, i_clk, i_rst_n,
        o_strobe && !o_last_result, busy, "idle mid burst")
    `CSS_ASSERT_NXT(a_drop_steady, i_clk, i_rst_n,
        o_strobe && !o_last_result, $stable(o_dropped), "drop flag changed within set")
    `CSS_ASSERT_NXT(a_sort_begins, i_clk, i_rst_n,
        start && !busy && i_last_of_set, busy, "sort not started")

endmodule

bind cocktail_shaker_sorter_unit css_checker u_css_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_of_set  (i_last_of_set),
    .o_strobe       (o_strobe),
    .o_last_result  (o_last_result),
    .o_dropped      (o_dropped)
);
